/* rtl/dtfp_pkg.sv */
// Shared constants, types and the power-of-ten table for the decimal text parser.
`default_nettype none
package dtfp_pkg;

  localparam logic [3:0] MAX_FRAC_DIGITS = 4'd9;
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned STEP_W = $clog2(DIV_STEPS);

  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_POINT = 8'd46;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  // Status from the divider back to the parser.
  typedef struct packed {
    logic        busy;
    logic        hold;
    logic [31:0] quot;
  } dtfp_div_res_t;

  function automatic logic [29:0] pow10(input logic [3:0] n);
    logic [29:0] p;
    case (n)
      4'd0:    p = 30'd1;
      4'd1:    p = 30'd10;
      4'd2:    p = 30'd100;
      4'd3:    p = 30'd1000;
      4'd4:    p = 30'd10000;
      4'd5:    p = 30'd100000;
      4'd6:    p = 30'd1000000;
      4'd7:    p = 30'd10000000;
      4'd8:    p = 30'd100000000;
      4'd9:    p = 30'd1000000000;
      default: p = 30'd1;
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

/* rtl/dtfp_div.sv */
// Bit-serial restoring divider: 32 quotient bits of frac * 2^32 / 10^n, rounded.
`default_nettype none
module dtfp_div (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [29:0]          dividend,
  input  wire logic [29:0]          divisor,
  input  wire logic                 take,
  output dtfp_pkg::dtfp_div_res_t   res
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_RND, D_HOLD} dstate_t;

  dstate_t                      state_r;
  logic [dtfp_pkg::STEP_W-1:0]  cnt_r;
  logic [29:0]                  rem_r;
  logic [29:0]                  div_r;
  logic [31:0]                  quot_r;

  logic [30:0] shifted;
  logic [30:0] diff;
  logic        ge;
  logic [29:0] rem_step;
  logic        round_up;

  assign shifted  = {rem_r, 1'b0};
  assign ge       = shifted >= {1'b0, div_r};
  assign diff     = shifted - {1'b0, div_r};
  assign rem_step = ge ? diff[29:0] : shifted[29:0];
  // Round up only when twice the remainder exceeds the divisor.
  assign round_up = {rem_r, 1'b0} > {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        D_IDLE: begin
          if (start) begin
            state_r <= D_RUN;
            cnt_r   <= '0;
            rem_r   <= dividend;
            div_r   <= divisor;
            quot_r  <= '0;
          end
        end
        D_RUN: begin
          quot_r <= {quot_r[30:0], ge};
          rem_r  <= rem_step;
          cnt_r  <= cnt_r + 1'b1;
          if (cnt_r == dtfp_pkg::STEP_W'(dtfp_pkg::DIV_STEPS - 1)) begin
            state_r <= D_RND;
          end
        end
        D_RND: begin
          if (round_up) begin
            quot_r <= quot_r + 32'd1;
          end
          state_r <= D_HOLD;
        end
        D_HOLD: begin
          if (take) begin
            state_r <= D_IDLE;
          end
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

  assign res.busy = (state_r != D_IDLE);
  assign res.hold = (state_r == D_HOLD);
  assign res.quot = quot_r;

endmodule
`default_nettype wire

/* rtl/decimal_text_to_fixed_point_unit.sv */
// Top level: character parser, divider control and result register.
//
// Decimal text to signed 32.32 fixed point. Feed the string one byte per
// beat on in_ch, marking its final byte with in_last. The accepted form is
// optional leading whitespace, an optional minus, an optional plus, integer
// digits, an optional point and fraction digits; a NUL or whitespace ends the
// number and the rest of the string up to the last byte is ignored. Every
// byte except the last is taken without a stall while the divider is idle,
// so a string streams at one character per clock. The last byte hands the
// kept fraction (at most nine digits) to a one-bit-per-cycle restoring
// divider, which forms 32 quotient bits and then rounds them, after which
// the sign is applied as the result is loaded into the output register. The
// next string's first byte is taken once the divider has handed its
// quotient to the output register. One result beat comes out per string:
// out_ok is 0 and both parts are zero on a syntax error. The integer part
// wraps modulo 2^32.
`default_nettype none
module decimal_text_to_fixed_point_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_ok,
  output logic [31:0]      out_int_part,
  output logic [31:0]      out_frac_part
);

  typedef enum logic [2:0] {
    PH_LEAD, PH_MINUS, PH_PLUS, PH_INT, PH_FRAC, PH_DONE, PH_ERR
  } phase_t;

  // Parse state
  phase_t       phase_r, phase_nxt;
  logic         neg_r, neg_nxt;
  logic [31:0]  whole_r, whole_nxt;
  logic [29:0]  tenths_r, tenths_nxt;
  logic [3:0]   cnt_r, cnt_nxt;

  // Captured at the last byte, waiting for the divider
  logic         fin_ok_r;
  logic         fin_neg_r;
  logic [31:0]  fin_int_r;

  // Result register
  logic         out_valid_r;
  logic         out_ok_r;
  logic [31:0]  out_int_r;
  logic [31:0]  out_frac_r;

  dtfp_pkg::dtfp_div_res_t div_res;

  logic        accept;
  logic        start;
  logic        take;
  logic        is_ws;
  logic        is_dig;
  logic [3:0]  digit;
  logic        ok_nxt;
  logic [31:0] whole_mac;
  logic [29:0] tenths_mac;
  logic [31:0] neg_frac;
  logic [31:0] neg_int;

  assign in_ready = !div_res.busy;
  assign accept   = in_valid && in_ready;
  assign start    = accept && in_last;
  // Move the quotient out once the result register is free or being drained.
  assign take     = div_res.hold && (!out_valid_r || out_ready);

  assign is_ws  = (in_ch == dtfp_pkg::CH_SPACE) ||
                  ((in_ch >= dtfp_pkg::CH_TAB) && (in_ch <= dtfp_pkg::CH_CR));
  assign is_dig = (in_ch >= dtfp_pkg::CH_ZERO) && (in_ch <= dtfp_pkg::CH_NINE);
  assign digit  = 4'(in_ch - dtfp_pkg::CH_ZERO);

  // Multiply by ten as x*8 + x*2, then add the digit.
  assign whole_mac  = {whole_r[28:0], 3'b000} + {whole_r[30:0], 1'b0} + 32'(digit);
  assign tenths_mac = {tenths_r[26:0], 3'b000} + {tenths_r[28:0], 1'b0} + 30'(digit);

  always_comb begin
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    whole_nxt  = whole_r;
    tenths_nxt = tenths_r;
    cnt_nxt    = cnt_r;
    case (phase_r)
      PH_LEAD, PH_MINUS, PH_PLUS: begin
        if ((phase_r == PH_LEAD) && is_ws) begin
          phase_nxt = PH_LEAD;
        end else if ((phase_r == PH_LEAD) && (in_ch == dtfp_pkg::CH_MINUS)) begin
          neg_nxt   = 1'b1;
          phase_nxt = PH_MINUS;
        end else if ((phase_r != PH_PLUS) && (in_ch == dtfp_pkg::CH_PLUS)) begin
          phase_nxt = PH_PLUS;
        end else if (is_dig) begin
          whole_nxt = 32'(digit);
          phase_nxt = PH_INT;
        end else if (in_ch == dtfp_pkg::CH_POINT) begin
          phase_nxt = PH_FRAC;
        end else begin
          phase_nxt = PH_ERR;
        end
      end
      PH_INT: begin
        if (is_dig) begin
          whole_nxt = whole_mac;
        end else if ((in_ch == dtfp_pkg::CH_NUL) || is_ws) begin
          phase_nxt = PH_DONE;
        end else if (in_ch == dtfp_pkg::CH_POINT) begin
          phase_nxt = PH_FRAC;
        end else begin
          phase_nxt = PH_ERR;
        end
      end
      PH_FRAC: begin
        if (is_dig) begin
          // Skip digits past the kept precision.
          if (cnt_r < dtfp_pkg::MAX_FRAC_DIGITS) begin
            tenths_nxt = tenths_mac;
            cnt_nxt    = cnt_r + 4'd1;
          end
        end else if ((in_ch == dtfp_pkg::CH_NUL) || is_ws) begin
          phase_nxt = PH_DONE;
        end else begin
          phase_nxt = PH_ERR;
        end
      end
      PH_DONE: begin
        phase_nxt = PH_DONE;
      end
      default: begin
        phase_nxt = PH_ERR;
      end
    endcase
  end

  assign ok_nxt = (phase_nxt == PH_INT) || (phase_nxt == PH_FRAC) ||
                  (phase_nxt == PH_DONE);

  // Two's complement of the 64-bit value: the carry out of the low word
  // reaches the high word only when the fraction is zero.
  assign neg_frac = ~div_res.quot + 32'd1;
  assign neg_int  = ~fin_int_r + {31'd0, (div_res.quot == 32'd0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_LEAD;
      neg_r       <= 1'b0;
      whole_r     <= '0;
      tenths_r    <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (start) begin
        // Return to the reset state for the next string.
        phase_r  <= PH_LEAD;
        neg_r    <= 1'b0;
        whole_r  <= '0;
        tenths_r <= '0;
        cnt_r    <= '0;
      end else if (accept) begin
        phase_r  <= phase_nxt;
        neg_r    <= neg_nxt;
        whole_r  <= whole_nxt;
        tenths_r <= tenths_nxt;
        cnt_r    <= cnt_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (start) begin
      fin_ok_r  <= ok_nxt;
      fin_neg_r <= neg_nxt;
      fin_int_r <= whole_nxt;
    end
    if (take) begin
      out_ok_r <= fin_ok_r;
      if (!fin_ok_r) begin
        out_int_r  <= '0;
        out_frac_r <= '0;
      end else if (fin_neg_r) begin
        out_int_r  <= neg_int;
        out_frac_r <= neg_frac;
      end else begin
        out_int_r  <= fin_int_r;
        out_frac_r <= div_res.quot;
      end
    end
  end

  dtfp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .dividend (tenths_nxt),
    .divisor  (dtfp_pkg::pow10(cnt_nxt)),
    .take     (take),
    .res      (div_res)
  );

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_int_part  = out_int_r;
  assign out_frac_part = out_frac_r;

  // The final byte of a string hands off to the divider and blocks input.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !in_ready)
    else $error("input still ready after final byte");

  // Parser is back in its reset state right after a final byte.
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (phase_r == PH_LEAD) && !neg_r && (cnt_r == 4'd0))
    else $error("parser not reset after final byte");

  // A failed parse reports zero parts.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_int_part == 32'd0) && (out_frac_part == 32'd0))
    else $error("nonzero parts on syntax error");

  // Kept fraction digits never exceed the precision limit.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= dtfp_pkg::MAX_FRAC_DIGITS)
    else $error("fraction digit count out of range");

  // A result is loaded only into a free or draining output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_int_part) && $stable(out_frac_part))
    else $error("result overwritten while stalled");

endmodule
`default_nettype wire
